// File: sv/rgbpwm_pkg.sv
// shared types, constants and codes for the rgb led pwm frame builder
`default_nettype none
package rgbpwm_pkg;

	// frame geometry
	localparam int LED_COUNT    = 8;
	localparam int PAD_WORDS    = 50;
	localparam int BITS_PER_LED = 24;
	localparam int LED_WORDS    = LED_COUNT * BITS_PER_LED;
	localparam int FRAME_LEN    = LED_WORDS + PAD_WORDS;

	localparam int ADDR_W = (LED_WORDS > 1) ? $clog2(LED_WORDS) : 1;
	localparam int ROW_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int BIT_W  = $clog2(BITS_PER_LED);
	localparam int WORD_W = 16;

	// word index to led row: floor(i / 24) as (i * ROW_RECIP) >> ROW_SHIFT, exact below 192
	localparam int ROW_RECIP = 2731;
	localparam int ROW_SHIFT = 16;

	// pulse widths: 2*period/7 and 2*period/3 by reciprocal multiply plus one correction
	localparam int RECIP_SHIFT  = 20;
	localparam int LO_DIV       = 7;
	localparam int HI_DIV       = 3;
	localparam int LO_RECIP     = 149796;
	localparam int HI_RECIP     = 349525;

	localparam logic [15:0] PWM_PERIOD_RESET = 16'd107;

	// register map
	localparam logic REG_PWM_PERIOD = 1'b0;

	typedef enum logic [1:0] {
		OP_FILL = 2'd0,
		OP_SET  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_LED_RANGE   = 2'd1;
	localparam logic [1:0] STAT_INDEX_RANGE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAIT,
		ST_DECODE,
		ST_WRITE,
		ST_RDWAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  led_number;
		logic [23:0] colour;
		logic [7:0]  word_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] read_word;
	} rsp_t;

	typedef struct packed {
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
	} pulse_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [ROW_W-1:0]  wrow;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic [ROW_W-1:0]  rrow;
	} mem_req_t;

endpackage
`default_nettype wire

// File: sv/rgbpwm_pulse_calc.sv
// two-stage pipeline deriving low and high pulse compare values from the pwm period
`default_nettype none
module rgbpwm_pulse_calc
	import rgbpwm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [15:0] pwm_period,
	output pulse_t           pulses
);

	logic [16:0] x;
	logic [35:0] prod_lo;
	logic [35:0] prod_hi;
	logic [16:0] x_s1;
	logic [15:0] q_lo_s1;
	logic [15:0] q_hi_s1;
	logic [17:0] rem_lo;
	logic [17:0] rem_hi;
	logic [15:0] lo_s2;
	logic [15:0] hi_s2;

	assign x       = {pwm_period, 1'b0};
	assign prod_lo = 36'(x) * 36'(LO_RECIP);
	assign prod_hi = 36'(x) * 36'(HI_RECIP);

	always_ff @(posedge clk) begin
		x_s1    <= x;
		q_lo_s1 <= 16'(prod_lo >> RECIP_SHIFT);
		q_hi_s1 <= 16'(prod_hi >> RECIP_SHIFT);
	end

	// estimate is exact or one low
	assign rem_lo = {1'b0, x_s1} - 18'(q_lo_s1) * 18'(LO_DIV);
	assign rem_hi = {1'b0, x_s1} - 18'(q_hi_s1) * 18'(HI_DIV);

	always_ff @(posedge clk) begin
		lo_s2 <= (rem_lo >= 18'(LO_DIV)) ? q_lo_s1 + 16'd1 : q_lo_s1;
		hi_s2 <= (rem_hi >= 18'(HI_DIV)) ? q_hi_s1 + 16'd1 : q_hi_s1;
	end

	assign pulses.lo = lo_s2;
	assign pulses.hi = hi_s2;

endmodule
`default_nettype wire

// File: sv/rgbpwm_frame_mem.sv
// frame word memory with one valid bit per led row and registered read
`default_nettype none
module rgbpwm_frame_mem
	import rgbpwm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mem_req_t    req,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [LED_WORDS];
	logic [LED_COUNT-1:0] valid_q;
	logic [WORD_W-1:0] rdata_s1;
	logic              rvalid_s1;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_s1  <= mem[req.raddr];
			rvalid_s1 <= valid_q[req.rrow];
		end
	end

	// a row never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.we) begin
			valid_q[req.wrow] <= 1'b1;
		end
	end

	assign rdata = rvalid_s1 ? rdata_s1 : '0;

endmodule
`default_nettype wire

// File: sv/rgbpwm_ctrl.sv
// command sequencer: decodes a command, sweeps frame writes or issues a read, returns status
`default_nettype none
module rgbpwm_ctrl
	import rgbpwm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire cmd_t         cmd,
	input  wire pulse_t       pulses,
	input  wire logic [WORD_W-1:0] rdata,
	output logic              busy,
	output logic              done,
	output rsp_t              rsp,
	output mem_req_t          req
);

	state_t state_q, state_d;
	cmd_t   cmd_q;
	rsp_t   rsp_q, rsp_d;

	logic [ADDR_W-1:0]       addr_q;
	logic [ADDR_W-1:0]       last_q;
	logic [ROW_W-1:0]        row_q;
	logic [BIT_W-1:0]        bit_q;
	logic [BITS_PER_LED-1:0] grb_sh_q;
	logic                    fill_q;

	logic                    load_all;
	logic                    load_one;
	logic                    step;
	logic [BITS_PER_LED-1:0] grb;
	logic [ROW_W-1:0]        led_row;
	logic [ADDR_W-1:0]       base;
	logic [ROW_W-1:0]        read_row;

	assign grb      = {cmd_q.colour[15:8], cmd_q.colour[23:16], cmd_q.colour[7:0]};
	assign led_row  = ROW_W'(cmd_q.led_number - 4'd1);
	assign base     = ADDR_W'(led_row) * ADDR_W'(BITS_PER_LED);
	assign read_row = ROW_W'((24'(cmd_q.word_index) * 24'(ROW_RECIP)) >> ROW_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rsp_d     = rsp_q;
		load_all  = 1'b0;
		load_one  = 1'b0;
		step      = 1'b0;
		busy      = 1'b1;
		done      = 1'b0;
		req       = '0;
		req.waddr = addr_q;
		req.wrow  = row_q;
		req.wdata = (fill_q || !grb_sh_q[BITS_PER_LED-1]) ? pulses.lo : pulses.hi;
		req.raddr = ADDR_W'(cmd_q.word_index);
		req.rrow  = read_row;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_WAIT;
				end
			end
			// lets the pulse pipeline settle on the current period
			ST_WAIT: begin
				state_d = ST_DECODE;
			end
			ST_DECODE: begin
				rsp_d.status    = STAT_OK;
				rsp_d.read_word = '0;
				state_d         = ST_DONE;
				case (op_t'(cmd_q.opcode))
					OP_FILL: begin
						load_all = 1'b1;
						state_d  = ST_WRITE;
					end
					OP_SET: begin
						if (32'(cmd_q.led_number) > 32'(LED_COUNT)) begin
							rsp_d.status = STAT_LED_RANGE;
						end else if (cmd_q.led_number == 4'd0) begin
							load_all = 1'b1;
							state_d  = ST_WRITE;
						end else begin
							load_one = 1'b1;
							state_d  = ST_WRITE;
						end
					end
					OP_READ: begin
						if (32'(cmd_q.word_index) >= 32'(FRAME_LEN)) begin
							rsp_d.status = STAT_INDEX_RANGE;
						end else if (32'(cmd_q.word_index) < 32'(LED_WORDS)) begin
							req.re  = 1'b1;
							state_d = ST_RDWAIT;
						end
						// padding words read as zero
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_WRITE: begin
				req.we = 1'b1;
				step   = 1'b1;
				if (addr_q == last_q) begin
					state_d = ST_DONE;
				end
			end
			ST_RDWAIT: begin
				rsp_d.read_word = rdata;
				state_d         = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= cmd;
		end
		rsp_q <= rsp_d;
		if (load_all) begin
			addr_q   <= '0;
			last_q   <= ADDR_W'(LED_WORDS - 1);
			row_q    <= '0;
			bit_q    <= '0;
			fill_q   <= (op_t'(cmd_q.opcode) == OP_FILL);
			grb_sh_q <= grb;
		end else if (load_one) begin
			addr_q   <= base;
			last_q   <= base + ADDR_W'(BITS_PER_LED - 1);
			row_q    <= led_row;
			bit_q    <= '0;
			fill_q   <= 1'b0;
			grb_sh_q <= grb;
		end else if (step) begin
			addr_q <= addr_q + ADDR_W'(1);
			if (bit_q == BIT_W'(BITS_PER_LED - 1)) begin
				bit_q    <= '0;
				row_q    <= row_q + ROW_W'(1);
				grb_sh_q <= grb;
			end else begin
				bit_q    <= bit_q + BIT_W'(1);
				grb_sh_q <= grb_sh_q << 1;
			end
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

// File: sv/rgb_led_pwm_frame_builder_unit.sv
// top level: register port, pulse pipeline, sequencer and frame memory
`default_nettype none
// Builds a frame of pwm compare words for a chain of addressable rgb leds: 24 words per
// led (green, red, blue, msb first) followed by padding words that always read zero.
// A command is taken when start is high and busy is low; its single result appears on
// rsp while done is high for one cycle and cannot be held off. Every command passes
// through a wait state for the pulse pipeline and a decode state, then: fill or set-all
// writes one frame word per cycle through the single memory write port (all 192 led
// words), a single led set writes 24, a read of a led word waits on the registered
// memory output, and anything else goes straight on. done comes in the cycle after
// that, and busy drops after it. pwm_period is written over the apb-style port at byte
// address 0 and is sampled through the pulse pipeline at each frame word write.
module rgb_led_pwm_frame_builder_unit
	import rgbpwm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        start,
	input  wire cmd_t        cmd,
	output logic             busy,
	output logic             done,
	output rsp_t             rsp
);

	logic [15:0]       pwm_period_q;
	pulse_t            pulses;
	mem_req_t          req;
	logic [WORD_W-1:0] rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= PWM_PERIOD_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_PWM_PERIOD) begin
			pwm_period_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == REG_PWM_PERIOD) ? {16'd0, pwm_period_q} : 32'd0;

	rgbpwm_pulse_calc u_pulse (
		.clk       (clk),
		.pwm_period(pwm_period_q),
		.pulses    (pulses)
	);

	rgbpwm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.pulses(pulses),
		.rdata (rdata),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp),
		.req   (req)
	);

	rgbpwm_frame_mem u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rdata (rdata)
	);

endmodule
`default_nettype wire

// File: sv/rgbpwm_checker.sv
// port-level checks on the command handshake and result strobe, bound to the top level
`default_nettype none
module rgbpwm_checker
	import rgbpwm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t rsp
);

	// the result is strobed for one cycle only
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted command did not raise busy");

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobed while idle");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != STAT_OK |-> rsp.read_word == 16'd0)
		else $error("error status with nonzero read word");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == STAT_OK || rsp.status == STAT_LED_RANGE ||
			rsp.status == STAT_INDEX_RANGE))
		else $error("unused status code");

endmodule

bind rgb_led_pwm_frame_builder_unit rgbpwm_checker u_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);
`default_nettype wire
